// ----- rtl/mfcb_pkg.sv -----
// Shared types and constants of the cropped-border median filter.
// No dependencies; mfcb_ctrl, mfcb_dp, the top level and the testbench import this package.
package mfcb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 2;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int WIN_SIZE   = WIN_SIDE * WIN_SIDE;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT) + 1;
    localparam int RING_W  = $clog2(RING_ROWS);
    localparam int ADDR_W  = RING_W + COL_W;
    localparam int RAM_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int CNT_W   = $clog2(WIN_SIZE + 1);
    localparam int IDX_W   = $clog2(WIN_SIZE);
    localparam int PIX_W   = 8;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int RAD_W    = 2;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GATHER,
        S_FLUSH,
        S_MED_A,
        S_MED_B
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic gather_init;
        logic issue;
        logic load_lo;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic win_ready;
        logic gather_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/mfcb_in_if.sv -----
// Request channel of the median filter: valid/ready handshake with command and pixel.
// Depends on nothing.
interface mfcb_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink (input valid, input cmd, input pixel, output ready);
endinterface

// ----- rtl/mfcb_out_if.sv -----
// Result channel of the median filter: valid/ready handshake with filtered pixel.
// Depends on nothing.
interface mfcb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered;
    logic       frame_end;

    modport source (output valid, output filtered, output frame_end, input ready);
    modport sink (input valid, input filtered, input frame_end, output ready);
endinterface

// ----- rtl/mfcb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mfcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/mfcb_ctrl.sv -----
// Controller of the median filter: sequences store, window gather, median pick and output.
// Depends on mfcb_pkg.
module mfcb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mfcb_pkg::t_dp_sts i_sts,
    output mfcb_pkg::t_dp_cmd o_cmd
);
    import mfcb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.win_ready ? S_GATHER : S_IDLE;
            end
            S_GATHER: begin
                if (i_sts.gather_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_MED_A;
            S_MED_A: n_state = S_MED_B;
            S_MED_B: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:   o_cmd.in_ready = 1'b1;
            S_CHECK:  o_cmd.gather_init = i_sts.win_ready;
            S_GATHER: o_cmd.issue = 1'b1;
            S_FLUSH:  o_cmd = '0;
            S_MED_A:  o_cmd.load_lo = 1'b1;
            S_MED_B:  o_cmd.load_out = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end
endmodule

// ----- rtl/mfcb_dp.sv -----
// Datapath of the median filter: configuration, counters, line store, insertion sorter,
// median pick and output register. Depends on mfcb_pkg and mfcb_ram.
module mfcb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mfcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mfcb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_cmd,
    input  logic [mfcb_pkg::PIX_W-1:0]    i_in_pixel,
    input  logic                          i_out_ready,
    input  mfcb_pkg::t_dp_cmd             i_cmd,
    output mfcb_pkg::t_dp_sts             o_sts,
    output logic                          o_out_valid,
    output logic [mfcb_pkg::PIX_W-1:0]    o_out_filtered,
    output logic                          o_out_frame_end
);
    import mfcb_pkg::*;

    localparam logic [RING_W-1:0] RING_LAST = RING_W'(RING_ROWS - 1);
    localparam logic [RING_W:0]   RING_N    = (RING_W+1)'(RING_ROWS);

    logic [WIDTH_W-1:0]  r_cfg_w;
    logic [HEIGHT_W-1:0] r_cfg_h;
    logic [RAD_W-1:0]    r_cfg_rx;
    logic [RAD_W-1:0]    r_cfg_ry;

    logic [WIDTH_W-1:0]  w_eff;
    logic [ROW_W-1:0]    h_eff;
    logic [RAD_W-1:0]    rx;
    logic [RAD_W-1:0]    ry;

    logic [ROW_W-1:0]  r_in_row, r_out_row, r_cur_row;
    logic [COL_W-1:0]  r_in_col, r_out_col, r_cur_col;
    logic [RING_W-1:0] r_in_ring, r_out_ring, r_cur_ring;

    logic [PIX_W-1:0] r_srt [WIN_SIZE];
    logic [CNT_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic [PIX_W-1:0] r_lo;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_filt;
    logic             r_out_end;

    logic             in_acc, in_store;
    logic [COL_W:0]   in_col_inc;
    logic [ROW_W:0]   row_sum;
    logic [ROW_W-1:0] nr, r0;
    logic [COL_W:0]   col_sum;
    logic [COL_W-1:0] nc, c0, w_last;
    logic [ROW_W-1:0] h_last;
    logic [RING_W-1:0] ring0;
    logic             last_pix, out_free;
    logic [PIX_W-1:0] rd_data;
    logic [WIN_SIZE-1:0] keep;
    logic [IDX_W-1:0] idx_lo, idx_hi;
    logic [PIX_W:0]   avg_sum;

    // Effective configuration after clamping.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (r_cfg_w > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = ROW_W'(1);
        end else if (ROW_W'(r_cfg_h) > ROW_W'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(r_cfg_h);
        end
        rx = (r_cfg_rx > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_cfg_rx;
        ry = (r_cfg_ry > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_cfg_ry;
    end

    assign w_last = COL_W'(w_eff - WIDTH_W'(1));
    assign h_last = h_eff - ROW_W'(1);

    assign in_acc     = i_in_valid && i_cmd.in_ready;
    assign in_store   = in_acc && (i_in_cmd == CMD_PIXEL) && (r_in_row < h_eff);
    assign in_col_inc = {1'b0, r_in_col} + (COL_W+1)'(1);

    // Window bounds of the pending output pixel, cropped at the borders.
    always_comb begin
        row_sum = {1'b0, r_out_row} + (ROW_W+1)'(ry);
        nr      = (row_sum < {1'b0, h_eff}) ? row_sum[ROW_W-1:0] : h_last;
        col_sum = {1'b0, r_out_col} + (COL_W+1)'(rx);
        nc      = (col_sum < (COL_W+1)'(w_eff)) ? col_sum[COL_W-1:0] : w_last;
        c0      = (r_out_col >= COL_W'(rx)) ? r_out_col - COL_W'(rx) : '0;
        if (r_out_row >= ROW_W'(ry)) begin
            r0 = r_out_row - ROW_W'(ry);
            if (r_out_ring >= RING_W'(ry)) begin
                ring0 = r_out_ring - RING_W'(ry);
            end else begin
                ring0 = RING_W'(({1'b0, r_out_ring} + RING_N) - (RING_W+1)'(ry));
            end
        end else begin
            r0    = '0;
            ring0 = '0;
        end
    end

    assign last_pix = (r_out_row == h_last) && (r_out_col == w_last);
    assign out_free = !r_out_vld || i_out_ready;

    assign o_sts.win_ready = (r_out_row < h_eff) &&
                             ((nr < r_in_row) || ((nr == r_in_row) && (nc < r_in_col)));
    assign o_sts.gather_last = (r_cur_row == nr) && (r_cur_col == nc);
    assign o_sts.out_free    = out_free;

    mfcb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RAM_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (in_store),
        .i_waddr ({r_in_ring, r_in_col}),
        .i_wdata (i_in_pixel),
        .i_raddr ({r_cur_ring, r_cur_col}),
        .o_rdata (rd_data)
    );

    // Configuration and frame counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= WIDTH_W'(640);
            r_cfg_h    <= HEIGHT_W'(480);
            r_cfg_rx   <= RAD_W'(1);
            r_cfg_ry   <= RAD_W'(1);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:    r_cfg_w  <= i_cfg_data[WIDTH_W-1:0];
                REG_HEIGHT:   r_cfg_h  <= i_cfg_data[HEIGHT_W-1:0];
                REG_RADIUS_X: r_cfg_rx <= i_cfg_data[RAD_W-1:0];
                REG_RADIUS_Y: r_cfg_ry <= i_cfg_data[RAD_W-1:0];
                default:      r_cfg_w  <= r_cfg_w;
            endcase
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
        end else begin
            if (i_cmd.load_out && last_pix) begin
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_ring  <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_ring <= '0;
            end else begin
                if (in_store) begin
                    if (in_col_inc >= (COL_W+1)'(w_eff)) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + ROW_W'(1);
                        r_in_ring <= (r_in_ring == RING_LAST) ? '0 : r_in_ring + RING_W'(1);
                    end else begin
                        r_in_col <= in_col_inc[COL_W-1:0];
                    end
                end
                if (i_cmd.load_out) begin
                    if (r_out_col == w_last) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + ROW_W'(1);
                        r_out_ring <= (r_out_ring == RING_LAST) ? '0 : r_out_ring + RING_W'(1);
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // Gather cursor walks the cropped window row by row, one read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.gather_init) begin
            r_cur_row  <= r0;
            r_cur_ring <= ring0;
            r_cur_col  <= c0;
        end else if (i_cmd.issue) begin
            if (r_cur_col == nc) begin
                r_cur_col  <= c0;
                r_cur_row  <= r_cur_row + ROW_W'(1);
                r_cur_ring <= (r_cur_ring == RING_LAST) ? '0 : r_cur_ring + RING_W'(1);
            end else begin
                r_cur_col <= r_cur_col + COL_W'(1);
            end
        end
    end

    // Insertion sorter: each returned pixel drops into its sorted place as it arrives.
    always_comb begin
        for (int k = 0; k < WIN_SIZE; k++) begin
            keep[k] = (CNT_W'(k) < r_cnt) && !(r_srt[k] > rd_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.gather_init) begin
                r_cnt <= '0;
            end else if (r_rd_vld) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            for (int k = 0; k < WIN_SIZE; k++) begin
                if (keep[k]) begin
                    r_srt[k] <= r_srt[k];
                end else if (k == 0) begin
                    r_srt[k] <= rd_data;
                end else if (keep[k-1]) begin
                    r_srt[k] <= rd_data;
                end else begin
                    r_srt[k] <= r_srt[k-1];
                end
            end
        end
    end

    // Median pick: lower middle first, then the upper middle and the floored mean.
    assign idx_lo  = IDX_W'((r_cnt - CNT_W'(1)) >> 1);
    assign idx_hi  = IDX_W'(r_cnt >> 1);
    assign avg_sum = {1'b0, r_lo} + {1'b0, r_srt[idx_hi]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_lo) begin
            r_lo <= r_srt[idx_lo];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_filt <= avg_sum[PIX_W:1];
            r_out_end  <= last_pix;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_out_filtered  = r_out_filt;
    assign o_out_frame_end = r_out_end;
endmodule

// ----- rtl/median_filter_cropped_border.sv -----
// Streaming 2-D median filter with cropped borders; top level joining controller and datapath.
// The result of a request that completes a window is built from its N in-bounds neighbors
// (1 to 25), read one by one through the single read port of the line store; a new request
// is taken only once the last one is through, including any stall on the result side.
// Reset is synchronous, active low: counters, control, config and valid flags go to defaults.
// Depends on mfcb_pkg, mfcb_in_if, mfcb_out_if, mfcb_ram, mfcb_ctrl and mfcb_dp.
module median_filter_cropped_border (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mfcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mfcb_pkg::CFG_W-1:0]     i_cfg_data,
    mfcb_in_if.sink                        i_req,
    mfcb_out_if.source                     o_res
);
    import mfcb_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller takes a request only while idle. A pixel request within the
    // frame is written into the line store at the accepting edge. The controller
    // then checks whether the next output pixel has all its neighbors; if so it
    // walks the cropped window through the line store one pixel per cycle,
    // feeding an insertion sorter, and picks the middle value (or the floored mean
    // of the two middle values) into the output register.
    mfcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    mfcb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_req.valid),
        .i_in_cmd        (i_req.cmd),
        .i_in_pixel      (i_req.pixel),
        .i_out_ready     (o_res.ready),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .o_out_valid     (o_res.valid),
        .o_out_filtered  (o_res.filtered),
        .o_out_frame_end (o_res.frame_end)
    );

    assign i_req.ready = dp_cmd.in_ready;

    // Only one controller command may be active in any cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.in_ready, dp_cmd.gather_init, dp_cmd.issue,
                  dp_cmd.load_lo, dp_cmd.load_out}))
        else $error("more than one controller command active");

    // A taken request makes the block busy for at least the following cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted back to back");

    // A new result is only loaded when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !dp_cmd.load_out)
        else $error("pending result overwritten");
endmodule

// ----- tb/tb_median_filter_cropped_border.sv -----
// Self-checking testbench of the cropped-border median filter.
// Depends on mfcb_pkg, mfcb_in_if, mfcb_out_if and the median_filter_cropped_border RTL.
module tb_median_filter_cropped_border;
    import mfcb_pkg::*;

    // One filtered pixel as it should leave the block.
    typedef struct {
        logic [PIX_W-1:0] filtered;
        logic             frame_end;
    } t_pixel_result;

    // Cycles after the last expected pixel before the block is taken as idle.
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    mfcb_in_if  req_if ();
    mfcb_out_if res_if ();

    median_filter_cropped_border dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // Own copy of the filter state: line ring, raster counters and the
    // effective (saturated) frame geometry.
    logic [PIX_W-1:0] line_ring [RING_ROWS*MAX_WIDTH];
    int pix_row, pix_col, med_row, med_col;
    int img_w, img_h, rad_x, rad_y;

    t_pixel_result expected_pixels [$];
    int  mismatches;
    int  requests_sent;
    bit  no_idle;
    bit  hold_req;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ring_addr(int row, int col);
        return (row % RING_ROWS) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    // Median of the in-bounds neighborhood; neighbors off the image are dropped.
    // An even count gives the floored mean of the two middle values.
    function automatic logic [PIX_W-1:0] window_median(int row, int col);
        logic [PIX_W-1:0] vals [WIN_SIZE];
        logic [PIX_W-1:0] v;
        int n, r0, r1, c0, c1, j;
        n  = 0;
        r0 = (row >= rad_y) ? row - rad_y : 0;
        r1 = (row + rad_y < img_h) ? row + rad_y : img_h - 1;
        c0 = (col >= rad_x) ? col - rad_x : 0;
        c1 = (col + rad_x < img_w) ? col + rad_x : img_w - 1;
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                vals[n] = line_ring[ring_addr(r, c)];
                n++;
            end
        end
        for (int i = 1; i < n; i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > v) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        if (n % 2 == 1) begin
            return vals[n/2];
        end
        return PIX_W'((int'(vals[n/2-1]) + int'(vals[n/2])) / 2);
    endfunction

    function automatic void restart_frame();
        pix_row = 0;
        pix_col = 0;
        med_row = 0;
        med_col = 0;
    endfunction

    // Register write as the block sees it: zero sizes count as one and
    // oversized values saturate. Any write restarts the frame.
    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        int v;
        case (idx)
            REG_WIDTH: begin
                v = int'(val[WIDTH_W-1:0]);
                img_w = (v == 0) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : v);
            end
            REG_HEIGHT: begin
                v = int'(val[HEIGHT_W-1:0]);
                img_h = (v == 0) ? 1 : ((v > MAX_HEIGHT) ? MAX_HEIGHT : v);
            end
            REG_RADIUS_X: begin
                v = int'(val[RAD_W-1:0]);
                rad_x = (v > MAX_RADIUS) ? MAX_RADIUS : v;
            end
            REG_RADIUS_Y: begin
                v = int'(val[RAD_W-1:0]);
                rad_y = (v > MAX_RADIUS) ? MAX_RADIUS : v;
            end
            default: begin
            end
        endcase
        restart_frame();
    endfunction

    // Advance the filter state by one accepted request and queue the
    // filtered pixel that it releases, if any.
    function automatic void predict_filter(logic cmd, logic [PIX_W-1:0] pix);
        t_pixel_result res;
        int need_row, need_col;
        bit last;
        if (cmd == CMD_PIXEL && pix_row < img_h) begin
            line_ring[ring_addr(pix_row, pix_col)] = pix;
            pix_col++;
            if (pix_col >= img_w) begin
                pix_col = 0;
                pix_row++;
            end
        end
        if (med_row >= img_h) begin
            return;
        end
        need_row = (med_row + rad_y < img_h) ? med_row + rad_y : img_h - 1;
        need_col = (med_col + rad_x < img_w) ? med_col + rad_x : img_w - 1;
        if (!(need_row < pix_row || (need_row == pix_row && need_col < pix_col))) begin
            return;
        end
        last = (med_row == img_h - 1) && (med_col == img_w - 1);
        res.filtered  = window_median(med_row, med_col);
        res.frame_end = last;
        expected_pixels.insert(expected_pixels.size(), res);
        if (last) begin
            restart_frame();
        end else begin
            med_col++;
            if (med_col >= img_w) begin
                med_col = 0;
                med_row++;
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR: %s", what);
        mismatches++;
    endtask

    // Offer one request; a random gap may come first. Valid stays high
    // between back-to-back requests.
    task automatic send_request(logic cmd, logic [PIX_W-1:0] pix);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.pixel <= pix;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_filter(cmd, pix);
        requests_sent++;
    endtask

    // Lower valid, then wait until every expected pixel has come out and
    // the block has had time to finish any request with no result.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write enable stays high between back-to-back writes; the caller lowers it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        apply_config(idx, CFG_W'(val));
    endtask

    task automatic set_geometry(int w, int h, int rx, int ry);
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RADIUS_X, rx);
        write_reg(REG_RADIUS_Y, ry);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Feed up to max_pixels pixels of the frame, with drain ticks mixed in
    // if asked; a complete frame is then drained of results. A pixel offered
    // after the frame is complete is discarded and counts as a drain tick.
    task automatic stream_frame(int max_pixels, bit mixed_drains);
        int total;
        total = img_w * img_h;
        if (total > max_pixels) begin
            total = max_pixels;
        end
        for (int i = 0; i < total; i++) begin
            if (mixed_drains && $urandom_range(0, 9) == 0) begin
                send_request(CMD_DRAIN, PIX_W'($urandom));
            end
            send_request(CMD_PIXEL, pick_pixel());
        end
        while (pix_row >= img_h) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(CMD_PIXEL, PIX_W'($urandom));
            end else begin
                send_request(CMD_DRAIN, PIX_W'($urandom));
            end
        end
    endtask

    // Reset geometry is 640 x 480 with a 3 x 3 window; a partial first row
    // gives no result, and drain ticks mid-frame must give none either.
    task automatic test_reset_geometry();
        for (int i = 0; i < 12; i++) begin
            send_request(CMD_PIXEL, pick_pixel());
        end
        send_request(CMD_DRAIN, 8'h00);
        send_request(CMD_DRAIN, 8'hFF);
    endtask

    // Small frames with the extremes of every register, including zero sizes
    // (taken as one), radius three (saturated to two) and oversized widths
    // and heights (saturated), which are fed only in part.
    task automatic test_geometry_extremes();
        set_geometry(3, 3, 1, 1);
        stream_frame(9, 1'b0);
        set_geometry(0, 0, 0, 0);
        stream_frame(1, 1'b0);
        set_geometry(2, 2, 3, 3);
        stream_frame(4, 1'b0);
        set_geometry(4, 1, 2, 0);
        stream_frame(4, 1'b0);
        set_geometry(1, 5, 0, 2);
        stream_frame(5, 1'b0);
        set_geometry(2047, 8191, 0, 0);
        stream_frame(6, 1'b0);
        set_geometry(1024, 4096, 2, 2);
        stream_frame(4, 1'b0);
    endtask

    // Hold the result side off for a long stretch while requests keep
    // coming, so that the block backs up and stalls its input.
    task automatic test_output_backpressure();
        set_geometry(4, 4, 1, 1);
        hold_done = 1'b0;
        hold_req  = 1'b1;
        stream_frame(16, 1'b0);
        while (!hold_done) @(posedge i_clk);
    endtask

    // Random geometry per frame. Most frames are complete; some are cut
    // short and abandoned by the next register write.
    task automatic test_random_frames(int target);
        int w, h;
        while (requests_sent < target) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            h = $urandom_range(0, 7);
            set_geometry(w, h, $urandom_range(0, 3), $urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0) begin
                stream_frame($urandom_range(1, 12), 1'b1);
            end else begin
                stream_frame(1 << 30, 1'b1);
            end
        end
    endtask

    // Result side: random stalls in bursts, a long hold-off on request,
    // and always ready in the last part of the run.
    initial begin
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat (no_idle ? 1 : $urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Each accepted filtered pixel is matched against the oldest expected one.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %0d frame_end %0b",
                                          res_if.filtered, res_if.frame_end));
            end else begin
                want = expected_pixels.pop_front();
                if (res_if.filtered !== want.filtered) begin
                    report_mismatch($sformatf("filtered %0d, expected %0d",
                                              res_if.filtered, want.filtered));
                end
                if (res_if.frame_end !== want.frame_end) begin
                    report_mismatch($sformatf("frame_end %0b, expected %0b",
                                              res_if.frame_end, want.frame_end));
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side ends the run.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int outstanding;
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= REG_WIDTH;
        cfg_data     <= '0;
        req_if.valid <= 1'b0;
        req_if.cmd   <= CMD_PIXEL;
        req_if.pixel <= '0;
        mismatches    = 0;
        requests_sent = 0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        img_w = 640;
        img_h = 480;
        rad_x = 1;
        rad_y = 1;
        restart_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_geometry_extremes();
        test_output_backpressure();
        test_random_frames(1250);
        no_idle = 1'b1;
        test_random_frames(1400);

        wait_idle();
        outstanding = expected_pixels.size();
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
